// ----- design/reb_pkg.sv -----
// Shared types, event codes and the quadrature direction table for the
// rotary encoder and button decoder. No dependencies.
`default_nettype none

package reb_pkg;

    localparam int unsigned ThrWidth = 3;
    localparam int unsigned AccWidth = 5;

    localparam logic [ThrWidth-1:0] THR_RESET = 3'd3;
    localparam logic [1:0]          AB_RESET  = 2'b11;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CW       = 3'd1,
        EV_CCW      = 3'd2,
        EV_CW_HELD  = 3'd3,
        EV_CCW_HELD = 3'd4,
        EV_CLICK    = 3'd5
    } t_event;

    typedef enum logic {
        OP_CHANGE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        t_op  op;
        logic pin_a;
        logic pin_b;
        logic button_level;
        logic turn_lines_changed;
        logic button_line_changed;
    } t_item;

    // index: previous AB in bits 3:2, new AB in bits 1:0 (A in the low bit)
    localparam logic signed [1:0] DIR_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

// ----- design/reb_in_stage.sv -----
// Input register of the decoder: unpacks the slave-side transaction into an item.
// Depends on reb_pkg.
`default_nettype none

module reb_in_stage
    import reb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,
    input  wire        s_axis_tuser,
    output logic       o_item_valid,
    output t_item      o_item,
    input  wire        i_item_take
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign s_axis_tready = !r_valid || i_item_take;

    always_comb begin
        n_item.op                  = t_op'(s_axis_tuser);
        n_item.pin_a               = s_axis_tdata[0];
        n_item.pin_b               = s_axis_tdata[1];
        n_item.button_level        = s_axis_tdata[2];
        n_item.turn_lines_changed  = s_axis_tdata[3];
        n_item.button_line_changed = s_axis_tdata[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ----- design/reb_core.sv -----
// Decoder state, single-pass update and result register.
// Depends on reb_pkg.
`default_nettype none

module reb_core
    import reb_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [ThrWidth-1:0] i_cfg_wdata,
    input  wire                 i_item_valid,
    input  t_item               i_item,
    output logic                o_item_take,
    output logic                o_res_valid,
    output t_event              o_res_event,
    input  wire                 i_res_ready
);

    logic [ThrWidth-1:0]        r_thr;
    logic [1:0]                 r_prev_ab;
    logic [1:0]                 n_prev_ab;
    logic signed [AccWidth-1:0] r_acc;
    logic signed [AccWidth-1:0] n_acc;
    logic                       r_press;
    logic                       n_press;
    t_event                     r_event;
    t_event                     n_event;
    t_event                     n_res;
    logic                       r_res_valid;
    t_event                     r_res_event;
    logic signed [AccWidth-1:0] sum;
    logic signed [AccWidth-1:0] thr_s;
    logic [3:0]                 dir_idx;

    assign o_item_take = i_item_valid && (!r_res_valid || i_res_ready);

    always_comb begin
        n_prev_ab = r_prev_ab;
        n_acc     = r_acc;
        n_press   = r_press;
        n_event   = r_event;
        n_res     = r_event;
        dir_idx   = {r_prev_ab, i_item.pin_b, i_item.pin_a};
        thr_s     = $signed({{(AccWidth-ThrWidth){1'b0}}, r_thr});
        sum       = r_acc + AccWidth'(DIR_TABLE[dir_idx]);
        if (i_item.op == OP_READ) begin
            n_event = EV_NONE;
        end else begin
            if (i_item.turn_lines_changed) begin
                n_prev_ab = {i_item.pin_b, i_item.pin_a};
                n_acc     = sum;
                if (sum < -thr_s) begin
                    n_event = i_item.button_level ? EV_CCW : EV_CCW_HELD;
                    n_acc   = '0;
                end else if (sum > thr_s) begin
                    n_event = i_item.button_level ? EV_CW : EV_CW_HELD;
                    n_acc   = '0;
                end
                n_press = 1'b0;
            end
            if (i_item.button_line_changed) begin
                if (i_item.button_level) begin
                    if (n_press) begin
                        n_event = EV_CLICK;
                        n_press = 1'b0;
                    end
                end else begin
                    n_press = 1'b1;
                end
            end
            n_res = n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_prev_ab   <= AB_RESET;
            r_acc       <= '0;
            r_press     <= 1'b0;
            r_event     <= EV_NONE;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (o_item_take) begin
                r_prev_ab   <= n_prev_ab;
                r_acc       <= n_acc;
                r_press     <= n_press;
                r_event     <= n_event;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_res_event <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_event = r_res_event;

`ifndef ASSERT_OFF
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >= -5'sd8) && (r_acc <= 5'sd8))
        else $error("step accumulator out of range");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_take && i_item.op == OP_READ) |=>
            (r_event == EV_NONE) && (r_res_event == $past(r_event)))
        else $error("read transaction did not return and clear the event");

    a_idle_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_take && i_item.op == OP_CHANGE && !i_item.turn_lines_changed
            && !i_item.button_line_changed) |=>
            $stable(r_acc) && $stable(r_press) && $stable(r_event) && $stable(r_prev_ab))
        else $error("change transaction with no changed line altered state");

    a_click_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_take && i_item.op == OP_CHANGE && !r_press) |=>
            (r_event != EV_CLICK) || ($past(r_event) == EV_CLICK))
        else $error("click latched without a pending press");
`endif

endmodule

`default_nettype wire

// ----- design/rotary_encoder_button_decoder.sv -----
// Top level of the rotary encoder and push button event decoder.
// Depends on reb_pkg, reb_in_stage and reb_core.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser: op; tdata: pin_a, pin_b, button_level,
//                       turn_lines_changed, button_line_changed
//  m_axis    out        tdata: event_res
//  cfg       in         i_cfg_we, i_cfg_wdata: step_threshold
//
// One transaction per cycle while m_axis_tready keeps results flowing; each result
// passes the input register, then the result register, before it shows on m_axis.
// Synchronous active-low reset: threshold 3, previous AB 3, no event pending.
// A stalled result holds the result register; the input register takes one more
// transaction only while it is empty, and then s_axis_tready drops.
`default_nettype none

module rotary_encoder_button_decoder
    import reb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_wdata,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [0] pin_a, [1] pin_b, [2] button_level,
                                       // [3] turn_lines_changed, [4] button_line_changed
    input  wire        s_axis_tuser,   // [0] op
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] event_res
);

    logic   item_valid;
    t_item  item;
    logic   item_take;
    t_event res_event;

    reb_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_take   (item_take)
    );

    reb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_res_valid  (m_axis_tvalid),
        .o_res_event  (res_event),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, res_event};

endmodule

`default_nettype wire
